[src/rpnd_pkg.sv]
// Package with the shared types, constants and codes of the RPN/NRPN detector.
package rpnd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHAN_W = 5;
  localparam int CC_W = 7;
  localparam int DATA_W = 7;
  localparam int WORD_W = 14;

  localparam logic [CC_W-1:0] CC_NRPN_LSB = 7'h62;
  localparam logic [CC_W-1:0] CC_NRPN_MSB = 7'h63;
  localparam logic [CC_W-1:0] CC_RPN_LSB  = 7'h64;
  localparam logic [CC_W-1:0] CC_RPN_MSB  = 7'h65;
  localparam logic [CC_W-1:0] CC_DATA_MSB = 7'h06;
  localparam logic [CC_W-1:0] CC_DATA_LSB = 7'h26;

  localparam logic OP_CONTROL = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [CHAN_W-1:0] channel;
    logic [CC_W-1:0]   controller_number;
    logic [DATA_W-1:0] controller_value;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [WORD_W-1:0] parameter_number;
    logic [WORD_W-1:0] param_value;
    logic              is_nrpn;
    logic              is_fourteen_bit;
  } out_req_t;

  // One byte of the channel state: a set flag and the seven data bits.
  typedef struct packed {
    logic              set;
    logic [DATA_W-1:0] val;
  } half_t;

  typedef struct packed {
    half_t pm;
    half_t pl;
    half_t vm;
    half_t vl;
    logic  nrpn;
  } entry_t;

  localparam half_t HALF_UNSET = '{set: 1'b0, val: '1};
  localparam entry_t ENTRY_RESET = '{
    pm: HALF_UNSET, pl: HALF_UNSET, vm: HALF_UNSET, vl: HALF_UNSET, nrpn: 1'b0
  };

endpackage

[src/rpnd_state_mem.sv]
// Per-channel state memory with registered read and per-entry valid bits.
module rpnd_state_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr_all,
  input  logic                        rd_en,
  input  logic [rpnd_pkg::IDX_W-1:0]  rd_idx,
  output rpnd_pkg::entry_t            rd_data,
  input  logic                        wr_en,
  input  logic [rpnd_pkg::IDX_W-1:0]  wr_idx,
  input  rpnd_pkg::entry_t            wr_data
);

  rpnd_pkg::entry_t                        mem [rpnd_pkg::NUM_CHANNELS];
  logic [rpnd_pkg::NUM_CHANNELS-1:0]       vld_r;
  rpnd_pkg::entry_t                        rd_q_r;
  logic                                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : rpnd_pkg::ENTRY_RESET;

endmodule

[src/rpnd_update.sv]
// Next-state and result logic for one controller message on one channel.
module rpnd_update (
  input  rpnd_pkg::entry_t  cur,
  input  rpnd_pkg::in_req_t req,
  output rpnd_pkg::entry_t  nxt,
  output logic              wr,
  output logic              res_vld,
  output rpnd_pkg::out_req_t res
);

  rpnd_pkg::half_t v_half;
  logic            is_data;

  assign v_half = '{set: 1'b1, val: req.controller_value};

  always_comb begin
    nxt     = cur;
    wr      = 1'b1;
    is_data = 1'b0;
    case (req.controller_number)
      rpnd_pkg::CC_NRPN_LSB: begin
        nxt.pl   = v_half;
        nxt.vm   = rpnd_pkg::HALF_UNSET;
        nxt.vl   = rpnd_pkg::HALF_UNSET;
        nxt.nrpn = 1'b1;
      end
      rpnd_pkg::CC_NRPN_MSB: begin
        nxt.pm   = v_half;
        nxt.vm   = rpnd_pkg::HALF_UNSET;
        nxt.vl   = rpnd_pkg::HALF_UNSET;
        nxt.nrpn = 1'b1;
      end
      rpnd_pkg::CC_RPN_LSB: begin
        nxt.pl   = v_half;
        nxt.vm   = rpnd_pkg::HALF_UNSET;
        nxt.vl   = rpnd_pkg::HALF_UNSET;
        nxt.nrpn = 1'b0;
      end
      rpnd_pkg::CC_RPN_MSB: begin
        nxt.pm   = v_half;
        nxt.vm   = rpnd_pkg::HALF_UNSET;
        nxt.vl   = rpnd_pkg::HALF_UNSET;
        nxt.nrpn = 1'b0;
      end
      rpnd_pkg::CC_DATA_MSB: begin
        nxt.vm  = v_half;
        nxt.vl  = rpnd_pkg::HALF_UNSET;
        is_data = 1'b1;
      end
      rpnd_pkg::CC_DATA_LSB: begin
        nxt.vl  = v_half;
        is_data = 1'b1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_vld                 = is_data && nxt.pm.set && nxt.pl.set && nxt.vm.set;
    res.out_channel         = req.channel;
    res.parameter_number    = {nxt.pm.val, nxt.pl.val};
    res.is_nrpn             = nxt.nrpn;
    res.is_fourteen_bit     = nxt.vl.set;
    if (nxt.vl.set) begin
      res.param_value = {nxt.vm.val, nxt.vl.val};
    end else begin
      res.param_value = {{(rpnd_pkg::WORD_W - rpnd_pkg::DATA_W){1'b0}}, nxt.vm.val};
    end
  end

endmodule

[src/midi_rpn_nrpn_detector_core.sv]
// Top level of the MIDI RPN/NRPN detector: request pipeline, forwarding and output register.
//
// The block takes one request per cycle and sustains that rate while the
// result side does not stall. A request is accepted into a read stage, where
// the channel state memory is read; when it leaves the read stage the entry
// is updated, written back and any result is loaded into the output register.
// A write that lands in the same cycle as the next read of that channel is
// forwarded, so requests on the same channel may follow each other directly.
// The clear request resets all channels through the per-entry valid bits,
// and the block is ready for requests right after reset. Stalls on the result
// side only hold the pipeline when a result is waiting to be taken.
module midi_rpn_nrpn_detector_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpnd_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpnd_pkg::out_req_t out_data
);

  logic                         s1_valid_r;
  rpnd_pkg::in_req_t            s1_req_r;
  logic                         s1_fire;
  logic                         in_fire;
  logic                         s1_in_range;
  logic [rpnd_pkg::CHAN_W-1:0]  s1_ch_m1;
  logic [rpnd_pkg::IDX_W-1:0]   s1_idx;
  logic [rpnd_pkg::CHAN_W-1:0]  in_ch_m1;
  logic [rpnd_pkg::IDX_W-1:0]   in_idx;

  rpnd_pkg::entry_t             mem_rd;
  rpnd_pkg::entry_t             cur;
  rpnd_pkg::entry_t             upd_nxt;
  logic                         upd_wr;
  logic                         upd_res_vld;
  rpnd_pkg::out_req_t           upd_res;
  logic                         res_vld;
  logic                         wr_en;
  logic                         clr_all;

  logic                         byp_clr_r;
  logic                         byp_wr_r;
  logic [rpnd_pkg::IDX_W-1:0]   byp_idx_r;
  rpnd_pkg::entry_t             byp_data_r;

  logic                         out_valid_r;
  rpnd_pkg::out_req_t           out_data_r;

  assign in_ch_m1 = in_data.channel - rpnd_pkg::CHAN_W'(1);
  assign in_idx   = in_ch_m1[rpnd_pkg::IDX_W-1:0];
  assign s1_ch_m1 = s1_req_r.channel - rpnd_pkg::CHAN_W'(1);
  assign s1_idx   = s1_ch_m1[rpnd_pkg::IDX_W-1:0];
  assign s1_in_range = (s1_req_r.channel != '0) &&
                       (s1_req_r.channel <= rpnd_pkg::CHAN_W'(rpnd_pkg::NUM_CHANNELS));

  always_comb begin
    if (byp_clr_r) begin
      cur = rpnd_pkg::ENTRY_RESET;
    end else if (byp_wr_r && (byp_idx_r == s1_idx)) begin
      cur = byp_data_r;
    end else begin
      cur = mem_rd;
    end
  end

  rpnd_update u_update (
    .cur     (cur),
    .req     (s1_req_r),
    .nxt     (upd_nxt),
    .wr      (upd_wr),
    .res_vld (upd_res_vld),
    .res     (upd_res)
  );

  assign res_vld  = s1_valid_r && (s1_req_r.opcode == rpnd_pkg::OP_CONTROL) &&
                    s1_in_range && upd_res_vld;
  assign s1_fire  = s1_valid_r && (!res_vld || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign clr_all  = s1_fire && (s1_req_r.opcode == rpnd_pkg::OP_CLEAR);
  assign wr_en    = s1_fire && (s1_req_r.opcode == rpnd_pkg::OP_CONTROL) &&
                    s1_in_range && upd_wr;

  rpnd_state_mem u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_all (clr_all),
    .rd_en   (in_fire),
    .rd_idx  (in_idx),
    .rd_data (mem_rd),
    .wr_en   (wr_en),
    .wr_idx  (s1_idx),
    .wr_data (upd_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_clr_r   <= 1'b0;
      byp_wr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        byp_clr_r  <= clr_all;
        byp_wr_r   <= wr_en;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_data;
      byp_idx_r  <= s1_idx;
      byp_data_r <= upd_nxt;
    end
    if (s1_fire && res_vld) begin
      out_data_r <= upd_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
